>>> hdl/stq_pkg.sv
// Shared types, codes and default parameters of the sorted timer queue.
package stq_pkg;

    localparam int DEF_CAPACITY  = 16;
    localparam int DEF_ID_BITS   = 8;
    localparam int DEF_TIME_BITS = 32;

    localparam int ID_FIELD_BITS   = 8;
    localparam int TIME_FIELD_BITS = 32;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_ADJUST = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_TICK   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EXPIRED  = 3'd1,
        ST_NONE     = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_DUP      = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_POP    = 2'd3
    } t_cell_op;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_EXEC   = 2'd1,
        S_INSERT = 2'd2,
        S_TICK   = 2'd3
    } t_state;

    typedef struct packed {
        t_cmd                       cmd;
        logic [ID_FIELD_BITS-1:0]   timer_id;
        logic [TIME_FIELD_BITS-1:0] expire_time;
        logic [TIME_FIELD_BITS-1:0] now_time;
    } t_in_item;

    typedef struct packed {
        t_status                  status;
        logic [ID_FIELD_BITS-1:0] expired_id;
        logic                     last;
    } t_out_item;

endpackage

>>> hdl/stq_cell.sv
// One slot of the timer chain: holds an entry and moves it to or from its neighbors.
module stq_cell #(
    parameter int ID_BITS   = stq_pkg::DEF_ID_BITS,
    parameter int TIME_BITS = stq_pkg::DEF_TIME_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  stq_pkg::t_cell_op    i_op,
    input  logic [ID_BITS-1:0]   i_key_id,
    input  logic [TIME_BITS-1:0] i_key_time,
    input  logic                 i_left_le,
    input  logic                 i_left_valid,
    input  logic [ID_BITS-1:0]   i_left_id,
    input  logic [TIME_BITS-1:0] i_left_time,
    input  logic                 i_right_valid,
    input  logic [ID_BITS-1:0]   i_right_id,
    input  logic [TIME_BITS-1:0] i_right_time,
    input  logic                 i_hit_in,
    output logic                 o_valid,
    output logic [ID_BITS-1:0]   o_id,
    output logic [TIME_BITS-1:0] o_time,
    output logic                 o_le,
    output logic                 o_hit,
    output logic                 o_hit_out
);

    logic                 r_valid;
    logic [ID_BITS-1:0]   r_id;
    logic [TIME_BITS-1:0] r_time;
    logic                 n_valid;
    logic [ID_BITS-1:0]   n_id;
    logic [TIME_BITS-1:0] n_time;

    assign o_valid   = r_valid;
    assign o_id      = r_id;
    assign o_time    = r_time;
    assign o_le      = r_valid && (r_time <= i_key_time);
    assign o_hit     = r_valid && (r_id == i_key_id);
    assign o_hit_out = i_hit_in | o_hit;

    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        n_time  = r_time;
        case (i_op)
            stq_pkg::CELL_INSERT: begin
                if (!o_le) begin
                    if (i_left_le) begin
                        n_valid = 1'b1;
                        n_id    = i_key_id;
                        n_time  = i_key_time;
                    end else begin
                        n_valid = i_left_valid;
                        n_id    = i_left_id;
                        n_time  = i_left_time;
                    end
                end
            end
            stq_pkg::CELL_REMOVE: begin
                if (o_hit_out) begin
                    n_valid = i_right_valid;
                    n_id    = i_right_id;
                    n_time  = i_right_time;
                end
            end
            stq_pkg::CELL_POP: begin
                n_valid = i_right_valid;
                n_id    = i_right_id;
                n_time  = i_right_time;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_time <= n_time;
    end

endmodule

>>> hdl/sorted_timer_queue_top.sv
// Top level of the sorted timer queue: command sequencer, cell chain and result register.
//
//  channel | direction | valid       | ready       | payload
//  --------+-----------+-------------+-------------+----------------------
//  in      | input     | i_in_valid  | o_in_ready  | i_in  (t_in_item)
//  out     | output    | o_out_valid | i_out_ready | o_out (t_out_item)
//
// Add and delete make one pass over the chain; adjust makes a remove pass, then an insert pass.
// Tick pops each due entry from the head, one entry a cycle while the result register is free.
// Every entry moves at most one cell per cycle; each pass updates all cells of the chain at once.
// A full result register stalls the sequencer until the result transaction completes.
// Synchronous reset empties the queue at once.
module sorted_timer_queue_top #(
    parameter int CAPACITY  = stq_pkg::DEF_CAPACITY,
    parameter int ID_BITS   = stq_pkg::DEF_ID_BITS,
    parameter int TIME_BITS = stq_pkg::DEF_TIME_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  stq_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output stq_pkg::t_out_item o_out
);

    stq_pkg::t_state      r_state;
    stq_pkg::t_state      n_state;
    stq_pkg::t_cmd        r_cmd;
    logic [ID_BITS-1:0]   r_key_id;
    logic [TIME_BITS-1:0] r_key_time;
    logic                 r_out_valid;
    stq_pkg::t_out_item   r_out;

    logic                 w_accept;
    logic                 w_out_free;
    stq_pkg::t_cell_op    w_cell_op;
    logic                 w_emit;
    stq_pkg::t_status     w_status;
    logic                 w_emit_last;
    logic                 w_any_hit;
    logic                 w_full;

    logic [CAPACITY-1:0]  w_valid;
    logic [CAPACITY-1:0]  w_le;
    logic [CAPACITY-1:0]  w_hit;
    logic [CAPACITY-1:0]  w_hit_chain;
    logic [ID_BITS-1:0]   w_id   [CAPACITY];
    logic [TIME_BITS-1:0] w_time [CAPACITY];

    logic [CAPACITY-1:0]  w_left_le;
    logic [CAPACITY-1:0]  w_left_valid;
    logic [ID_BITS-1:0]   w_left_id    [CAPACITY];
    logic [TIME_BITS-1:0] w_left_time  [CAPACITY];
    logic [CAPACITY-1:0]  w_right_valid;
    logic [ID_BITS-1:0]   w_right_id   [CAPACITY];
    logic [TIME_BITS-1:0] w_right_time [CAPACITY];
    logic [CAPACITY-1:0]  w_hit_in;

    assign o_in_ready  = (r_state == stq_pkg::S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_any_hit   = w_hit_chain[CAPACITY-1];
    assign w_full      = w_valid[CAPACITY-1];
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        if (gi == 0) begin : g_head
            assign w_left_le[gi]    = 1'b1;
            assign w_left_valid[gi] = 1'b0;
            assign w_left_id[gi]    = r_key_id;
            assign w_left_time[gi]  = r_key_time;
            assign w_hit_in[gi]     = 1'b0;
        end else begin : g_body
            assign w_left_le[gi]    = w_le[gi-1];
            assign w_left_valid[gi] = w_valid[gi-1];
            assign w_left_id[gi]    = w_id[gi-1];
            assign w_left_time[gi]  = w_time[gi-1];
            assign w_hit_in[gi]     = w_hit_chain[gi-1];
        end
        if (gi == CAPACITY - 1) begin : g_tail
            assign w_right_valid[gi] = 1'b0;
            assign w_right_id[gi]    = w_id[gi];
            assign w_right_time[gi]  = w_time[gi];
        end else begin : g_inner
            assign w_right_valid[gi] = w_valid[gi+1];
            assign w_right_id[gi]    = w_id[gi+1];
            assign w_right_time[gi]  = w_time[gi+1];
        end

        stq_cell #(
            .ID_BITS   (ID_BITS),
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_op          (w_cell_op),
            .i_key_id      (r_key_id),
            .i_key_time    (r_key_time),
            .i_left_le     (w_left_le[gi]),
            .i_left_valid  (w_left_valid[gi]),
            .i_left_id     (w_left_id[gi]),
            .i_left_time   (w_left_time[gi]),
            .i_right_valid (w_right_valid[gi]),
            .i_right_id    (w_right_id[gi]),
            .i_right_time  (w_right_time[gi]),
            .i_hit_in      (w_hit_in[gi]),
            .o_valid       (w_valid[gi]),
            .o_id          (w_id[gi]),
            .o_time        (w_time[gi]),
            .o_le          (w_le[gi]),
            .o_hit         (w_hit[gi]),
            .o_hit_out     (w_hit_chain[gi])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            stq_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = stq_pkg::S_EXEC;
                end
            end
            stq_pkg::S_EXEC: begin
                if (w_out_free) begin
                    if (r_cmd == stq_pkg::CMD_ADJUST && w_any_hit) begin
                        n_state = stq_pkg::S_INSERT;
                    end else if (r_cmd == stq_pkg::CMD_TICK && w_le[0] && w_le[1]) begin
                        n_state = stq_pkg::S_TICK;
                    end else begin
                        n_state = stq_pkg::S_IDLE;
                    end
                end
            end
            stq_pkg::S_INSERT: begin
                if (w_out_free) begin
                    n_state = stq_pkg::S_IDLE;
                end
            end
            stq_pkg::S_TICK: begin
                if (w_out_free && !w_le[1]) begin
                    n_state = stq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = stq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        w_cell_op   = stq_pkg::CELL_HOLD;
        w_emit      = 1'b0;
        w_status    = stq_pkg::ST_OK;
        w_emit_last = 1'b1;
        case (r_state)
            stq_pkg::S_EXEC: begin
                if (w_out_free) begin
                    case (r_cmd)
                        stq_pkg::CMD_ADD: begin
                            w_emit = 1'b1;
                            if (w_any_hit) begin
                                w_status = stq_pkg::ST_DUP;
                            end else if (w_full) begin
                                w_status = stq_pkg::ST_FULL;
                            end else begin
                                w_cell_op = stq_pkg::CELL_INSERT;
                            end
                        end
                        stq_pkg::CMD_ADJUST: begin
                            if (w_any_hit) begin
                                w_cell_op = stq_pkg::CELL_REMOVE;
                            end else begin
                                w_emit   = 1'b1;
                                w_status = stq_pkg::ST_NOTFOUND;
                            end
                        end
                        stq_pkg::CMD_DELETE: begin
                            w_emit = 1'b1;
                            if (w_any_hit) begin
                                w_cell_op = stq_pkg::CELL_REMOVE;
                            end else begin
                                w_status = stq_pkg::ST_NOTFOUND;
                            end
                        end
                        stq_pkg::CMD_TICK: begin
                            w_emit = 1'b1;
                            if (w_le[0]) begin
                                w_cell_op   = stq_pkg::CELL_POP;
                                w_status    = stq_pkg::ST_EXPIRED;
                                w_emit_last = !w_le[1];
                            end else begin
                                w_status = stq_pkg::ST_NONE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            stq_pkg::S_INSERT: begin
                if (w_out_free) begin
                    w_cell_op = stq_pkg::CELL_INSERT;
                    w_emit    = 1'b1;
                end
            end
            stq_pkg::S_TICK: begin
                if (w_out_free) begin
                    w_cell_op   = stq_pkg::CELL_POP;
                    w_emit      = 1'b1;
                    w_status    = stq_pkg::ST_EXPIRED;
                    w_emit_last = !w_le[1];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= stq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd    <= i_in.cmd;
            r_key_id <= ID_BITS'(i_in.timer_id);
            if (i_in.cmd == stq_pkg::CMD_TICK) begin
                r_key_time <= TIME_BITS'(i_in.now_time);
            end else begin
                r_key_time <= TIME_BITS'(i_in.expire_time);
            end
        end
        if (w_emit) begin
            r_out.status     <= w_status;
            r_out.expired_id <= (w_status == stq_pkg::ST_EXPIRED)
                                ? stq_pkg::ID_FIELD_BITS'(w_id[0]) : '0;
            r_out.last       <= w_emit_last;
        end
    end

    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid >> 1) & ~w_valid) == '0)
        else $error("occupied cells are not contiguous from the head");

    a_sorted_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_le >> 1) & ~w_le) == '0)
        else $error("cell chain is out of expiry order");

    a_unique_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit))
        else $error("timer id held by more than one cell");

    a_tick_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stq_pkg::S_TICK) |-> w_le[0])
        else $error("tick drain with no due entry at the head");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (!o_in_ready && !$stable(r_state)))
        else $error("sequencer did not start on an accepted transaction");

endmodule
